FILE: rtl/core/ipda_pkg.sv
// Shared types and constants for the padded decimal ASCII converter.
package ipda_pkg;

  localparam int DEFAULT_MAX_FIELD_WIDTH = 32;
  localparam int DIGIT_DEPTH             = 10;

  // q = (v * RECIP_TEN) >> RECIP_SHIFT equals v / 10 for every 32-bit v
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_BLANK = 8'h20;

  typedef struct packed {
    logic signed [31:0] value;
    logic [5:0]         min_width;
  } req_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } rsp_t;

endpackage

FILE: rtl/core/ipda_div10.sv
// Shared divide-by-ten unit: registered reciprocal product, then remainder.
module ipda_div10 (
  input  logic        clk,
  input  logic [31:0] dividend,
  output logic [31:0] quotient,
  output logic [3:0]  remainder
);
  import ipda_pkg::*;

  logic [63:0] product;
  logic [31:0] times_ten;
  logic [31:0] diff;

  assign product = {32'b0, dividend} * {32'b0, RECIP_TEN};

  always_ff @(posedge clk) begin
    quotient <= 32'(product >> RECIP_SHIFT);
  end

  // Valid in the cycle after the dividend settles; the sequencer holds it.
  assign times_ten = {quotient[28:0], 3'b000} + {quotient[30:0], 1'b0};
  assign diff      = dividend - times_ten;
  assign remainder = diff[3:0];

endmodule

FILE: rtl/core/int_to_padded_decimal_ascii_top.sv
// Top level: sequencer, digit store and output register of the decimal converter.
// Sequence: accept, then a multiply state and a subtract state per decimal digit (1 to 10
// digits), then one character per cycle from the output register unless the output stalls.
// Each word gives max(clamped width, text length) characters; a new word is taken only once
// the last character of the previous word is loaded.
// Reset: synchronous rst clears the sequencer and output valid; the digit store is not cleared.
module int_to_padded_decimal_ascii_top #(
  parameter int MAX_FIELD_WIDTH = ipda_pkg::DEFAULT_MAX_FIELD_WIDTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  ipda_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output ipda_pkg::rsp_t rsp
);
  import ipda_pkg::*;

  localparam int         PosW   = $clog2(MAX_FIELD_WIDTH);
  localparam logic [6:0] MaxW7  = 7'(MAX_FIELD_WIDTH);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_SUB  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t      state;
  logic [31:0] work_value;
  logic [3:0]  digit_count;
  logic        negative_flag;
  logic [6:0]  width_clamp;
  logic [PosW-1:0] emit_left;
  logic [3:0]  digit_store [DIGIT_DEPTH];

  logic [31:0] quotient;
  logic [3:0]  remainder;
  logic        accept;
  logic        load;
  logic [3:0]  digit_count_next;
  logic [6:0]  text_len;
  logic [6:0]  total;
  logic [6:0]  req_width7;
  logic [7:0]  char_sel;

  ipda_div10 u_div10 (
    .clk       (clk),
    .dividend  (work_value),
    .quotient  (quotient),
    .remainder (remainder)
  );

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign load      = (state == S_EMIT) && (!rsp_valid || !rsp_stall);
  assign req_width7 = {1'b0, req.min_width};

  assign digit_count_next = digit_count + 4'd1;
  assign text_len = {3'b000, digit_count_next} + {6'b0, negative_flag};
  assign total    = (width_clamp > text_len) ? width_clamp : text_len;

  // emit_left counts down to the final character; digits sit at the low end
  always_comb begin
    if (emit_left <= PosW'(digit_count)) begin
      char_sel = CHAR_ZERO + {4'b0000, digit_store[emit_left[3:0]]};
    end else if (negative_flag && emit_left == PosW'(digit_count_next)) begin
      char_sel = CHAR_MINUS;
    end else begin
      char_sel = CHAR_BLANK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid   <= 1'b0;
      digit_count <= 4'd0;
      negative_flag <= 1'b0;
      work_value  <= 32'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            negative_flag <= req.value[31];
            work_value    <= req.value[31] ? (32'd0 - req.value) : req.value;
            width_clamp   <= (req_width7 > MaxW7) ? MaxW7 : req_width7;
            digit_count   <= 4'd0;
            state         <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_SUB;
        end
        S_SUB: begin
          digit_store[digit_count] <= remainder;
          work_value <= quotient;
          if (quotient == 32'd0 || digit_count_next == 4'(DIGIT_DEPTH)) begin
            emit_left <= PosW'(total - 7'd1);
            state     <= S_EMIT;
          end else begin
            digit_count <= digit_count_next;
            state       <= S_MUL;
          end
        end
        S_EMIT: begin
          if (load) begin
            emit_left <= emit_left - PosW'(1);
            if (emit_left == '0) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase

      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Hold the payload while the output word is stalled.
  always_ff @(posedge clk) begin
    if (load) begin
      rsp.char_out <= char_sel;
      rsp.last     <= (emit_left == '0);
    end
  end

  a_accept_starts_divide: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_MUL)
    else $error("accepted word did not start the divide sequence");

  a_remainder_is_digit: assert property (@(posedge clk) disable iff (rst)
    state == S_SUB |-> remainder < 4'd10)
    else $error("divide unit remainder out of range");

  a_last_ends_word: assert property (@(posedge clk) disable iff (rst)
    (load && emit_left == '0) |=> (state == S_IDLE && rsp_valid && rsp.last))
    else $error("final character did not close the word");

  a_digit_count_bound: assert property (@(posedge clk) disable iff (rst)
    digit_count < 4'(DIGIT_DEPTH))
    else $error("digit count exceeds store depth");

endmodule

FILE: bench/tb_int_to_padded_decimal_ascii_top.sv
// Self-checking bench for the padded decimal ASCII converter: directed table, then random words.
`timescale 1ns / 1ps
module tb_int_to_padded_decimal_ascii_top;
  import ipda_pkg::*;

  localparam int FIELD_LIMIT  = DEFAULT_MAX_FIELD_WIDTH;
  localparam int RANDOM_WORDS = 440;

  typedef logic [7:0] text_q_t[$];

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  rsp_t        pending_chars[$];
  int unsigned mismatches = 0;
  logic [7:0]  stall_pattern = 8'h00;
  int unsigned stall_age = 0;

  logic signed [31:0] row_value[$];
  logic [5:0]         row_width[$];
  string              row_text[$];

  int_to_padded_decimal_ascii_top uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Flag the final character of each number's text.
  function automatic void queue_text(text_q_t text);
    rsp_t ch;
    for (int i = 0; i < text.size(); i++) begin
      ch.char_out = text[i];
      ch.last     = (i == text.size() - 1);
      pending_chars.push_back(ch);
    end
  endfunction

  function automatic void format_decimal(logic signed [31:0] value, logic [5:0] min_width);
    logic [31:0] mag;
    logic [31:0] rem;
    logic [3:0]  digits[DIGIT_DEPTH];
    int          n_dig;
    int          field;
    int          text_len;
    text_q_t     text;
    mag = value[31] ? 32'd0 - $unsigned(value) : $unsigned(value);
    n_dig = 0;
    do begin
      rem = mag % 32'd10;
      digits[n_dig] = rem[3:0];
      n_dig++;
      mag = mag / 32'd10;
    end while (mag != 0);
    field = (min_width > FIELD_LIMIT) ? FIELD_LIMIT : min_width;
    text_len = n_dig + value[31];
    for (int i = text_len; i < field; i++) text.push_back(CHAR_BLANK);
    if (value[31]) text.push_back(CHAR_MINUS);
    for (int i = n_dig - 1; i >= 0; i--) text.push_back(CHAR_ZERO + digits[i]);
    queue_text(text);
  endfunction

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    logic signed [31:0] pow;
    pow = 1;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 20);
      2: begin
        repeat ($urandom_range(0, 9)) pow = pow * 10;
        v = pow + $urandom_range(0, 2) - 1;
      end
      3: v = $urandom_range(0, 1) ? 32'sh8000_0000 + $urandom_range(0, 3)
                                  : 32'sh7FFF_FFFF - $urandom_range(0, 3);
      4: v = $urandom_range(0, 999999);
      default: v = $urandom_range(0, 100000);
    endcase
    if ($urandom_range(0, 2) == 0 && v != 32'sh8000_0000) v = -v;
    return v;
  endfunction

  task automatic add_row(logic signed [31:0] value, logic [5:0] min_width, string text);
    row_value.push_back(value);
    row_width.push_back(min_width);
    row_text.push_back(text);
  endtask

  // An empty text means the row is checked against the predictor.
  task automatic send_word(logic signed [31:0] value, logic [5:0] min_width, string text);
    text_q_t chars;
    @(negedge clk);
    req_valid     <= 1'b1;
    req.value     <= value;
    req.min_width <= min_width;
    do @(posedge clk); while (req_stall);
    if (text.len() == 0) begin
      format_decimal(value, min_width);
    end else begin
      for (int i = 0; i < text.len(); i++) chars.push_back(text[i]);
      queue_text(chars);
    end
  endtask

  // Drop valid and scramble the idle payload.
  task automatic hold_off(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      req_valid     <= 1'b0;
      req.value     <= $urandom;
      req.min_width <= 6'($urandom_range(0, 63));
    end
  endtask

  always @(negedge clk) begin
    if (stall_age == 0) begin
      stall_age     <= $urandom_range(20, 80);
      stall_pattern <= ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(0, 127));
    end else begin
      stall_age     <= stall_age - 1;
      stall_pattern <= {stall_pattern[6:0], stall_pattern[7]};
    end
    rsp_stall <= stall_pattern[0];
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_chars.size() == 0) begin
        flag_mismatch($sformatf("unexpected char %h last %b", rsp.char_out, rsp.last));
      end else begin
        want = pending_chars.pop_front();
        if (rsp.char_out !== want.char_out)
          flag_mismatch($sformatf("char %h, want %h", rsp.char_out, want.char_out));
        if (rsp.last !== want.last)
          flag_mismatch($sformatf("last %b, want %b (char %h)", rsp.last, want.last,
                                  want.char_out));
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned burst;
    add_row(0, 0, "0");
    add_row(0, 1, "0");
    add_row(7, 3, "  7");
    add_row(-1, 0, "-1");
    add_row(-1, 2, "-1");
    add_row(-1, 3, " -1");
    add_row(10, 0, "10");
    add_row(-10, 1, "-10");
    add_row(32'sh7FFF_FFFF, 0, "2147483647");
    add_row(32'sh8000_0000, 0, "-2147483648");
    add_row(32'sh8000_0000, 11, "-2147483648");
    add_row(32'sh8000_0000, 12, " -2147483648");
    add_row(1000000000, 5, "1000000000");
    add_row(-999999999, 0, "-999999999");
    add_row(9, 10, "");
    add_row(0, 32, "");
    add_row(32'sh7FFF_FFFF, 32, "");
    add_row(32'sh8000_0000, 32, "");
    add_row(5, 33, "");
    add_row(5, 63, "");
    add_row(-123, 63, "");
    add_row(32'sh5555_5555, 42, "");
    add_row(-32'sh2AAA_AAAA, 21, "");

    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (row_value[i]) begin
      send_word(row_value[i], row_width[i], row_text[i]);
      if ($urandom_range(0, 2) == 0) hold_off($urandom_range(1, 3));
    end

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
      repeat (burst) begin
        send_word(pick_value(),
                  ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(0, 12)),
                  "");
        sent++;
      end
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 8));
    end

    hold_off(1);
    wait (pending_chars.size() == 0);
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
